FILE: rtl/core/hmt_pkg.sv
// Shared types and codes for the hook match table.
package hmt_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned HTYPE_W  = 4;
  localparam int unsigned TVAL_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 4;

  // Operation codes; the unused code behaves as a query.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [HTYPE_W-1:0] hook_type;
    logic [TVAL_W-1:0]  trig_value;
  } hmt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
  } hmt_out_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic               rem_en;
    logic [HTYPE_W-1:0] key_type;
    logic [TVAL_W-1:0]  key_value;
  } hmt_ctrl_t;

endpackage

FILE: rtl/core/hmt_cell.sv
// One slot of the match table: stored entry, compare and down-shift.
module hmt_cell #(
  parameter int unsigned TW = 4
) (
  input  logic                  clk,
  input  hmt_pkg::hmt_ctrl_t    ctrl,
  input  logic                  occupied,
  input  logic                  ins_sel,
  input  logic                  hit_in,
  output logic                  hit_out,
  input  logic [TW-1:0]         nb_type,
  input  logic [hmt_pkg::TVAL_W-1:0] nb_value,
  output logic [TW-1:0]         ent_type,
  output logic [hmt_pkg::TVAL_W-1:0] ent_value
);
  import hmt_pkg::*;

  logic [TW-1:0]     type_r;
  logic [TW-1:0]     type_nxt;
  logic [TVAL_W-1:0] value_r;
  logic [TVAL_W-1:0] value_nxt;
  logic              match;

  // Local hit, chained so hit_out means "a match at this slot or below".
  assign match   = occupied && (type_r == ctrl.key_type[TW-1:0]) &&
                   (value_r == ctrl.key_value);
  assign hit_out = hit_in | match;

  always_comb begin
    type_nxt  = type_r;
    value_nxt = value_r;
    priority if (ins_sel) begin
      type_nxt  = ctrl.key_type[TW-1:0];
      value_nxt = ctrl.key_value;
    end else if (ctrl.rem_en && hit_out) begin
      type_nxt  = nb_type;
      value_nxt = nb_value;
    end
  end

  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    value_r <= value_nxt;
  end

  assign ent_type  = type_r;
  assign ent_value = value_r;

endmodule

FILE: rtl/core/hook_match_table_unit.sv
// Top level of the hook match table: cell row, entry count and result register.
//
//  channel | ports                       | direction | moves
//  --------+-----------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_item | into unit | one operation per transfer
//  out     | out_valid, out_stall, out_item | out    | status and entry count
//
// For every operation, all cells compare against the key at once, a hit ripples
// up the row, and on removal each cell at or above the first hit loads its upper
// neighbour. The result lands in the output register in the cycle after the
// input transfer. Reset clears the entry count and the output valid only; slot
// contents stay undefined until written. The input stalls only while a result
// waits in the output register and the output is stalled.
module hook_match_table_unit #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned TYPE_BITS   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hmt_pkg::hmt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hmt_pkg::hmt_out_t out_item
);
  import hmt_pkg::*;

  // Type bits above the port width are always zero, so store no more than that.
  localparam int unsigned TW = (TYPE_BITS < HTYPE_W) ? TYPE_BITS : HTYPE_W;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  hmt_out_t          out_item_r;
  hmt_out_t          out_item_nxt;

  logic              accept;
  logic              is_ins;
  logic              is_rem;
  logic              full;
  logic              any_hit;
  hmt_ctrl_t         ctrl;

  logic [MAX_ENTRIES:0]  hit_chain;
  logic [TW-1:0]         ent_type  [MAX_ENTRIES];
  logic [TVAL_W-1:0]     ent_value [MAX_ENTRIES];

  // Handshake: result register frees when empty or being taken.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_ins  = accept && (in_item.operation == OP_INSERT);
  assign is_rem  = accept && (in_item.operation == OP_REMOVE);
  assign full    = (cnt_r == CW'(MAX_ENTRIES));
  assign any_hit = hit_chain[MAX_ENTRIES];

  assign ctrl.rem_en    = is_rem;
  assign ctrl.key_type  = in_item.hook_type;
  assign ctrl.key_value = in_item.trig_value;

  assign hit_chain[0] = 1'b0;

  // Cell row; the top cell shifts in its own contents (no neighbour above).
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [TW-1:0]     nb_type;
    logic [TVAL_W-1:0] nb_value;

    if (k + 1 < MAX_ENTRIES) begin : g_nb
      assign nb_type  = ent_type[k+1];
      assign nb_value = ent_value[k+1];
    end else begin : g_top
      assign nb_type  = ent_type[k];
      assign nb_value = ent_value[k];
    end

    hmt_cell #(
      .TW (TW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CW'(k) < cnt_r),
      .ins_sel   (is_ins && (cnt_r == CW'(k))),
      .hit_in    (hit_chain[k]),
      .hit_out   (hit_chain[k+1]),
      .nb_type   (nb_type),
      .nb_value  (nb_value),
      .ent_type  (ent_type[k]),
      .ent_value (ent_value[k])
    );
  end

  // Count update and result.
  always_comb begin
    cnt_nxt = cnt_r;
    if (is_ins && !full) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (is_rem && any_hit) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    out_item_nxt = out_item_r;
    if (accept) begin
      if (in_item.operation == OP_INSERT) begin
        out_item_nxt.status = full ? ST_FULL : ST_OK;
      end else begin
        out_item_nxt.status = any_hit ? ST_OK : ST_NONE;
      end
      out_item_nxt.entry_count = ECOUNT_W'(cnt_nxt);
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
